>>> sv/paup_pkg.sv
// Shared types and constants for the Pareto archive update core.
// Holds default parameters, item kinds and the controller/datapath command and status records.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package paup_pkg;

	localparam int DefArchiveDepth  = 64;
	localparam int DefMaxObjectives = 4;
	localparam int DefValueWidth    = 32;

	// Lanes stored per entry and port field widths
	localparam int Lanes      = 4;
	localparam int FieldWidth = 32;
	localparam int PosWidth   = 6;
	localparam int CountOutW  = 7;
	localparam int KindWidth  = 2;
	localparam int CfgDataW   = 3;
	localparam int InDataW    = 136;
	localparam int OutDataW   = 144;

	// Configuration register indexes
	localparam logic CFG_SORT_ENABLE = 1'b0;
	localparam logic CFG_OBJECTIVES  = 1'b1;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_READ   = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RA_I   = 2'd0,
		RA_JM1 = 2'd1,
		RA_POS = 2'd2
	} rd_sel_t;

	typedef enum logic {
		WA_KEPT = 1'b0,
		WA_J    = 1'b1
	} wa_sel_t;

	typedef enum logic [1:0] {
		WD_RDATA = 2'd0,
		WD_VEC   = 2'd1,
		WD_TMP   = 2'd2
	} wd_sel_t;

	typedef struct packed {
		logic    load_item;
		logic    i_clr;
		logic    i_one;
		logic    i_inc;
		logic    kept_clr;
		logic    kept_inc;
		logic    j_from_i;
		logic    j_dec;
		logic    tmp_load;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		logic    count_kept;
		logic    count_kept_inc;
		logic    count_clr;
		logic    set_changed;
		logic    set_full;
		logic    set_rvalid;
		logic    push;
	} cmd_t;

	typedef struct packed {
		logic i_lt_count;
		logic not_better;
		logic dominated;
		logic kept_full;
		logic sort_on;
		logic j_gt0;
		logic tmp_less;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> sv/pareto_archive_update_core.sv
// Top level of the Pareto archive update core: joins the controller and the datapath.
// Depends on paup_pkg, paup_ctrl and paup_datapath.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: kind; tdata: position, objective a..d
//  m_*       out  m_tvalid/m_tready   tdata: changed, full, count, read valid, read a..d
//  cfg_*     in   cfg_we              cfg_index, cfg_data
//
// Each request is handled alone. An insert scans the archive with a read and a compare
// state per entry, compacts it the same way and, when sorting is on, insertion-sorts it
// through a temporary; the archive memory has a registered read. A read passes through a
// memory read state, a clear goes straight to the result state. The output register holds
// a result while the next request is taken; a stalled output holds the controller in its
// result state. Reset empties the archive at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module pareto_archive_update_core
	import paup_pkg::*;
#(
	parameter int ARCHIVE_DEPTH  = DefArchiveDepth,
	parameter int MAX_OBJECTIVES = DefMaxObjectives,
	parameter int VALUE_WIDTH    = DefValueWidth
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// position[5:0], objective_a[37:6], objective_b[69:38], objective_c[101:70],
	// objective_d[133:102]
	input  wire logic [InDataW-1:0]   s_tdata,
	// kind[1:0]
	input  wire logic [KindWidth-1:0] s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// archive_changed[0], full_reject[1], entry_count[8:2], read_valid[9], read_a[41:10],
	// read_b[73:42], read_c[105:74], read_d[137:106]
	output logic [OutDataW-1:0]       m_tdata,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	paup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	paup_datapath #(
		.ARCHIVE_DEPTH  (ARCHIVE_DEPTH),
		.MAX_OBJECTIVES (MAX_OBJECTIVES),
		.VALUE_WIDTH    (VALUE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire

>>> sv/paup_datapath.sv
// Datapath of the Pareto archive update core: archive memory, counters, compare logic,
// configuration registers and the output register.
// Depends on paup_pkg.
`timescale 1ns / 1ps
`default_nettype none
module paup_datapath
	import paup_pkg::*;
#(
	parameter int ARCHIVE_DEPTH  = DefArchiveDepth,
	parameter int MAX_OBJECTIVES = DefMaxObjectives,
	parameter int VALUE_WIDTH    = DefValueWidth
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic [InDataW-1:0]    s_tdata,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CfgDataW-1:0]   cfg_data,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OutDataW-1:0]        m_tdata
);

	localparam int AW = (ARCHIVE_DEPTH > 1) ? $clog2(ARCHIVE_DEPTH) : 1;
	localparam int CW = $clog2(ARCHIVE_DEPTH + 1);
	localparam int XW = (CW > PosWidth) ? CW : PosWidth;
	localparam int EW = Lanes * VALUE_WIDTH;

	logic [EW-1:0] mem_q [ARCHIVE_DEPTH];
	logic [EW-1:0] rdata_q, vec_q, tmp_q;
	logic [CW-1:0] i_q, kept_q, j_q, count_q;
	logic [PosWidth-1:0] pos_q;
	logic sort_en_q;
	logic [CfgDataW-1:0] obj_q;
	logic changed_q, full_q, rvalid_q;

	logic [CW-1:0] jm1;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [EW-1:0] wr_data, vec_in;
	logic [CfgDataW-1:0] n_used;
	logic pos_hit, better, worse;
	logic [OutDataW-1:0] out_word;

	assign jm1 = j_q - CW'(1);
	assign pos_hit = XW'(pos_q) < XW'(count_q);

	// Clamp the objective count to 1..MAX_OBJECTIVES
	always_comb begin
		n_used = obj_q;
		if (n_used == '0) n_used = CfgDataW'(1);
		if (n_used > CfgDataW'(MAX_OBJECTIVES)) n_used = CfgDataW'(MAX_OBJECTIVES);
	end

	// Gather the input vector
	always_comb begin
		for (int k = 0; k < Lanes; k++) begin
			vec_in[k*VALUE_WIDTH +: VALUE_WIDTH] =
				VALUE_WIDTH'(s_tdata[PosWidth + k*FieldWidth +: FieldWidth]);
		end
	end

	// Dominance compare of the held vector against the read entry
	always_comb begin
		better = 1'b0;
		worse  = 1'b0;
		for (int k = 0; k < Lanes; k++) begin
			if (CfgDataW'(k) < n_used) begin
				if ($signed(vec_q[k*VALUE_WIDTH +: VALUE_WIDTH]) <
				    $signed(rdata_q[k*VALUE_WIDTH +: VALUE_WIDTH])) better = 1'b1;
				if ($signed(rdata_q[k*VALUE_WIDTH +: VALUE_WIDTH]) <
				    $signed(vec_q[k*VALUE_WIDTH +: VALUE_WIDTH])) worse = 1'b1;
			end
		end
	end

	// Status to the controller
	always_comb begin
		sts.i_lt_count = i_q < count_q;
		sts.not_better = !better;
		sts.dominated  = better && !worse;
		sts.kept_full  = kept_q == CW'(ARCHIVE_DEPTH);
		sts.sort_on    = sort_en_q && (n_used == CfgDataW'(2));
		sts.j_gt0      = j_q != '0;
		sts.tmp_less   =
			($signed(tmp_q[0 +: VALUE_WIDTH]) < $signed(rdata_q[0 +: VALUE_WIDTH])) ||
			((tmp_q[0 +: VALUE_WIDTH] == rdata_q[0 +: VALUE_WIDTH]) &&
			 ($signed(tmp_q[VALUE_WIDTH +: VALUE_WIDTH]) <
			  $signed(rdata_q[VALUE_WIDTH +: VALUE_WIDTH])));
		sts.out_free   = !m_tvalid || m_tready;
	end

	// Select memory addresses and write data
	always_comb begin
		case (cmd.rd_sel)
			RA_I:    rd_addr = i_q[AW-1:0];
			RA_JM1:  rd_addr = jm1[AW-1:0];
			RA_POS:  rd_addr = AW'(pos_q);
			default: rd_addr = i_q[AW-1:0];
		endcase
		wr_addr = (cmd.wa_sel == WA_J) ? j_q[AW-1:0] : kept_q[AW-1:0];
		case (cmd.wd_sel)
			WD_RDATA: wr_data = rdata_q;
			WD_VEC:   wr_data = vec_q;
			WD_TMP:   wr_data = tmp_q;
			default:  wr_data = rdata_q;
		endcase
	end

	// Archive memory
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem_q[wr_addr] <= wr_data;
		if (cmd.rd_en) rdata_q <= mem_q[rd_addr];
	end

	// Hold item payload and sort temporary
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			vec_q <= vec_in;
			pos_q <= s_tdata[PosWidth-1:0];
		end
		if (cmd.tmp_load) tmp_q <= rdata_q;
	end

	// Advance counters and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			kept_q    <= '0;
			j_q       <= '0;
			count_q   <= '0;
			changed_q <= 1'b0;
			full_q    <= 1'b0;
			rvalid_q  <= 1'b0;
		end else begin
			if (cmd.i_clr) i_q <= '0;
			else if (cmd.i_one) i_q <= CW'(1);
			else if (cmd.i_inc) i_q <= i_q + CW'(1);
			if (cmd.kept_clr) kept_q <= '0;
			else if (cmd.kept_inc) kept_q <= kept_q + CW'(1);
			if (cmd.j_from_i) j_q <= i_q;
			else if (cmd.j_dec) j_q <= jm1;
			if (cmd.count_clr) count_q <= '0;
			else if (cmd.count_kept) count_q <= kept_q;
			else if (cmd.count_kept_inc) count_q <= kept_q + CW'(1);
			if (cmd.load_item) begin
				changed_q <= 1'b0;
				full_q    <= 1'b0;
				rvalid_q  <= 1'b0;
			end else begin
				if (cmd.set_changed) changed_q <= 1'b1;
				if (cmd.set_full) full_q <= 1'b1;
				if (cmd.set_rvalid) rvalid_q <= pos_hit;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_en_q <= 1'b1;
			obj_q     <= CfgDataW'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SORT_ENABLE: sort_en_q <= cfg_data[0];
				CFG_OBJECTIVES:  obj_q <= cfg_data;
				default:         obj_q <= obj_q;
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.push) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Pack the result fields
	always_comb begin
		out_word = '0;
		out_word[0]   = changed_q;
		out_word[1]   = full_q;
		out_word[8:2] = CountOutW'(count_q);
		out_word[9]   = rvalid_q;
		for (int k = 0; k < Lanes; k++) begin
			out_word[10 + k*FieldWidth +: FieldWidth] = rvalid_q ?
				FieldWidth'(rdata_q[k*VALUE_WIDTH +: VALUE_WIDTH]) : '0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.push) m_tdata <= out_word;
	end

endmodule
`default_nettype wire

>>> sv/paup_ctrl.sv
// Controller of the Pareto archive update core: sequences scan, compaction, append,
// insertion sort, reads and clears by commands to the datapath.
// Depends on paup_pkg.
`timescale 1ns / 1ps
`default_nettype none
module paup_ctrl
	import paup_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [KindWidth-1:0] s_tuser,
	input  wire sts_t                 sts,
	output cmd_t                      cmd
);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'b0000_0000_0001,
		ST_SCAN     = 12'b0000_0000_0010,
		ST_SCAN_USE = 12'b0000_0000_0100,
		ST_CMP      = 12'b0000_0000_1000,
		ST_CMP_USE  = 12'b0000_0001_0000,
		ST_APPEND   = 12'b0000_0010_0000,
		ST_SORT_I   = 12'b0000_0100_0000,
		ST_SORT_TMP = 12'b0000_1000_0000,
		ST_SORT_J   = 12'b0001_0000_0000,
		ST_SORT_CMP = 12'b0010_0000_0000,
		ST_RD       = 12'b0100_0000_0000,
		ST_RESULT   = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	kind_t kind;

	assign kind = kind_t'(s_tuser);
	assign s_tready = state_q == ST_IDLE;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					case (kind)
						KIND_INSERT: begin
							cmd.i_clr = 1'b1;
							state_d = ST_SCAN;
						end
						KIND_READ: state_d = ST_RD;
						KIND_CLEAR: begin
							cmd.count_clr = 1'b1;
							state_d = ST_RESULT;
						end
						default: state_d = ST_RESULT;
					endcase
				end
			end
			// Look for an entry that dominates or equals the vector
			ST_SCAN: begin
				if (sts.i_lt_count) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_I;
					state_d = ST_SCAN_USE;
				end else begin
					cmd.i_clr = 1'b1;
					cmd.kept_clr = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_SCAN_USE: begin
				if (sts.not_better) begin
					state_d = ST_RESULT;
				end else begin
					cmd.i_inc = 1'b1;
					state_d = ST_SCAN;
				end
			end
			// Drop dominated entries and compact the rest
			ST_CMP: begin
				if (sts.i_lt_count) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_I;
					state_d = ST_CMP_USE;
				end else begin
					state_d = ST_APPEND;
				end
			end
			ST_CMP_USE: begin
				cmd.i_inc = 1'b1;
				if (sts.dominated) begin
					cmd.set_changed = 1'b1;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wa_sel = WA_KEPT;
					cmd.wd_sel = WD_RDATA;
					cmd.kept_inc = 1'b1;
				end
				state_d = ST_CMP;
			end
			ST_APPEND: begin
				if (sts.kept_full) begin
					cmd.count_kept = 1'b1;
					cmd.set_full = 1'b1;
					state_d = ST_RESULT;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wa_sel = WA_KEPT;
					cmd.wd_sel = WD_VEC;
					cmd.count_kept_inc = 1'b1;
					cmd.set_changed = 1'b1;
					if (sts.sort_on) begin
						cmd.i_one = 1'b1;
						state_d = ST_SORT_I;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			// Stable insertion sort by first, then second objective
			ST_SORT_I: begin
				if (sts.i_lt_count) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_I;
					state_d = ST_SORT_TMP;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SORT_TMP: begin
				cmd.tmp_load = 1'b1;
				cmd.j_from_i = 1'b1;
				state_d = ST_SORT_J;
			end
			ST_SORT_J: begin
				if (sts.j_gt0) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = RA_JM1;
					state_d = ST_SORT_CMP;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wa_sel = WA_J;
					cmd.wd_sel = WD_TMP;
					cmd.i_inc = 1'b1;
					state_d = ST_SORT_I;
				end
			end
			ST_SORT_CMP: begin
				cmd.wr_en = 1'b1;
				cmd.wa_sel = WA_J;
				if (sts.tmp_less) begin
					cmd.wd_sel = WD_RDATA;
					cmd.j_dec = 1'b1;
					state_d = ST_SORT_J;
				end else begin
					cmd.wd_sel = WD_TMP;
					cmd.i_inc = 1'b1;
					state_d = ST_SORT_I;
				end
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_sel = RA_POS;
				cmd.set_rvalid = 1'b1;
				state_d = ST_RESULT;
			end
			// Hand the result to the output register once it is free
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire
